/* rtl/core/tgs_pkg.sv */
// ----------------------------------------------------------------------------
// tgs_pkg
// Shared types, codes and arithmetic helpers of the trilinear grid sampler.
// ----------------------------------------------------------------------------
package tgs_pkg;

  localparam int unsigned AXIS_CELLS_DEF    = 16;
  localparam int unsigned CHANNEL_COUNT_DEF = 4;

  localparam int unsigned POS_W   = 32;
  localparam int unsigned INV_W   = 24;
  localparam int unsigned GSIZE_W = 5;
  localparam int unsigned LEVEL_W = 16;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned CH_W    = 3;
  localparam int unsigned WIDX_W  = 14;
  localparam int unsigned CFG_AW  = 3;
  localparam int unsigned CFG_DW  = 32;
  localparam int unsigned CORNERS = 8;
  localparam int unsigned DIFF_W  = POS_W + 1;
  localparam int unsigned PROD_W  = DIFF_W + INV_W + 1;
  localparam int unsigned FLOOR_W = PROD_W - 32;

  localparam logic [LEVEL_W-1:0] HALF_Q15 = 16'd16384;
  localparam logic [LEVEL_W:0]   ONE_Q15  = 17'd32768;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_QUERY = 2'd1,
    OP_BAKE  = 2'd2
  } opcode_e;

  typedef enum logic [CFG_AW-1:0] {
    CFG_ORIGIN_X  = 3'd0,
    CFG_ORIGIN_Y  = 3'd1,
    CFG_ORIGIN_Z  = 3'd2,
    CFG_INV_CELL  = 3'd3,
    CFG_GRID_X    = 3'd4,
    CFG_GRID_Y    = 3'd5,
    CFG_GRID_Z    = 3'd6,
    CFG_DYN_ENRG  = 3'd7
  } cfg_idx_e;

  // item control carried down the address pipeline
  typedef struct packed {
    logic                valid;
    logic [1:0]          op;
    logic [CH_W-1:0]     ch;
    logic [WIDX_W-1:0]   widx;
    logic [LEVEL_W-1:0]  wval;
  } item_ctl_t;

  // item control and fractions from the address stage to the store
  typedef struct packed {
    item_ctl_t           item;
    logic [FRAC_W-1:0]   fx;
    logic [FRAC_W-1:0]   fy;
    logic [FRAC_W-1:0]   fz;
  } addr_req_t;

  // query control from the store to the blend stages
  typedef struct packed {
    logic                valid;
    logic                blend_en;
    logic                ch_zero;
    logic [FRAC_W-1:0]   fx;
    logic [FRAC_W-1:0]   fy;
    logic [FRAC_W-1:0]   fz;
  } blend_req_t;

  // (a*(65536-f) + b*f + 32768) >> 16, with one multiply
  function automatic logic [LEVEL_W-1:0] lerp16(input logic [LEVEL_W-1:0] a,
                                                input logic [LEVEL_W-1:0] b,
                                                input logic [FRAC_W-1:0]  f);
    logic signed [LEVEL_W:0] dlt;
    logic signed [34:0]      s;
    dlt = $signed({1'b0, b}) - $signed({1'b0, a});
    s   = $signed({3'b0, a, 16'b0}) + 35'(dlt * $signed({1'b0, f})) + 35'sd32768;
    return s[31:16];
  endfunction

endpackage

/* rtl/core/tgs_addr.sv */
// ----------------------------------------------------------------------------
// tgs_addr
// Maps a position to grid space, clamps the corners and forms eight addresses.
// ----------------------------------------------------------------------------
module tgs_addr #(
  parameter int unsigned AXIS_CELLS    = tgs_pkg::AXIS_CELLS_DEF,
  parameter int unsigned CHANNEL_COUNT = tgs_pkg::CHANNEL_COUNT_DEF,
  parameter int unsigned AW            = 14,
  parameter int unsigned SW            = 5,
  parameter int unsigned GW            = 9
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  tgs_pkg::item_ctl_t              item_i,
  input  logic [2:0][tgs_pkg::POS_W-1:0]  pos_i,
  input  logic [2:0][tgs_pkg::POS_W-1:0]  origin_i,
  input  logic [tgs_pkg::INV_W-1:0]       inv_i,
  input  logic [2:0][SW-1:0]              gsize_i,
  input  logic [GW-1:0]                   gxy_i,
  output tgs_pkg::addr_req_t              req_o,
  output logic [tgs_pkg::CORNERS-1:0][AW-1:0] addr_o
);
  import tgs_pkg::*;

  localparam int unsigned IW = (AXIS_CELLS > 1) ? $clog2(AXIS_CELLS) : 1;

  item_ctl_t                     s1_q, s2_q, s3_q;
  logic [2:0][DIFF_W-1:0]        d_q;
  logic [2:0][PROD_W-1:0]        p_q;
  logic [2:0][IW-1:0]            lo_d, lo_q, hi_d, hi_q;
  logic [2:0][FRAC_W-1:0]        f_q;
  addr_req_t                     req_q;
  logic [CORNERS-1:0][AW-1:0]    addr_d, addr_q;

  always_comb begin
    logic signed [FLOOR_W-1:0] c;
    logic signed [FLOOR_W-1:0] top;
    logic [IW:0]               nxt;
    for (int a = 0; a < 3; a++) begin
      c   = $signed(p_q[a][PROD_W-1:32]);
      top = $signed(FLOOR_W'(gsize_i[a] - SW'(1)));
      if (c < 0) begin
        lo_d[a] = '0;
      end else if (c > top) begin
        lo_d[a] = IW'(top);
      end else begin
        lo_d[a] = IW'(c);
      end
      nxt = {1'b0, lo_d[a]} + (IW+1)'(1);
      if ((IW+1)'(nxt) > (IW+1)'(top)) begin
        hi_d[a] = IW'(top);
      end else begin
        hi_d[a] = IW'(nxt);
      end
    end
  end

  always_comb begin
    logic [AW-1:0] xs, ys, zs;
    for (int b = 0; b < CORNERS; b++) begin
      xs = AW'(b[0] ? hi_q[0] : lo_q[0]);
      ys = AW'(b[1] ? hi_q[1] : lo_q[1]);
      zs = AW'(b[2] ? hi_q[2] : lo_q[2]);
      addr_d[b] = AW'((zs * AW'(gxy_i) + ys * AW'(gsize_i[0]) + xs) * AW'(CHANNEL_COUNT)
                  + AW'(s3_q.ch));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q  <= '0;
      s2_q  <= '0;
      s3_q  <= '0;
      req_q <= '0;
    end else if (en_i) begin
      s1_q       <= item_i;
      s2_q       <= s1_q;
      s3_q       <= s2_q;
      req_q.item <= s3_q;
      req_q.fx   <= f_q[0];
      req_q.fy   <= f_q[1];
      req_q.fz   <= f_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int a = 0; a < 3; a++) begin
        d_q[a]  <= $signed({pos_i[a][POS_W-1], pos_i[a]})
                 - $signed({origin_i[a][POS_W-1], origin_i[a]});
        p_q[a]  <= PROD_W'($signed(d_q[a]) * $signed({1'b0, inv_i}));
        lo_q[a] <= lo_d[a];
        hi_q[a] <= hi_d[a];
        f_q[a]  <= p_q[a][31:16];
      end
      addr_q <= addr_d;
    end
  end

  assign req_o  = req_q;
  assign addr_o = addr_q;

endmodule

/* rtl/core/tgs_store.sv */
// ----------------------------------------------------------------------------
// tgs_store
// Sample store: eight copies, one per corner, written together. Holds the
// baked flag and runs the fill to one half after reset.
// ----------------------------------------------------------------------------
module tgs_store #(
  parameter int unsigned CHANNEL_COUNT = tgs_pkg::CHANNEL_COUNT_DEF,
  parameter int unsigned DEPTH         = 16384,
  parameter int unsigned AW            = 14
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  tgs_pkg::addr_req_t                   req_i,
  input  logic [tgs_pkg::CORNERS-1:0][AW-1:0]  addr_i,
  output tgs_pkg::blend_req_t                  req_o,
  output logic [tgs_pkg::CORNERS-1:0][tgs_pkg::LEVEL_W-1:0] data_o,
  output logic                                 clearing_o
);
  import tgs_pkg::*;

  logic                 clearing_q;
  logic [AW-1:0]        clr_q;
  logic                 baked_q;
  blend_req_t           req_q;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [LEVEL_W-1:0]   wdata;
  logic                 wr_hit;

  assign wr_hit = req_i.item.valid && (req_i.item.op == OP_WRITE)
                  && (32'(req_i.item.widx) < 32'(DEPTH));

  always_comb begin
    if (clearing_q) begin
      we    = 1'b1;
      waddr = clr_q;
      wdata = HALF_Q15;
    end else begin
      we    = en_i && wr_hit;
      waddr = AW'(req_i.item.widx);
      wdata = req_i.item.wval;
    end
  end

  for (genvar b = 0; b < CORNERS; b++) begin : g_bank
    logic [LEVEL_W-1:0] mem [DEPTH];
    logic [LEVEL_W-1:0] rd_q;
    always_ff @(posedge clk_i) begin
      if (we) begin
        mem[waddr] <= wdata;
      end
      if (en_i) begin
        rd_q <= mem[addr_i[b]];
      end
    end
    assign data_o[b] = rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q      <= '0;
      baked_q    <= 1'b0;
      req_q      <= '0;
    end else begin
      if (clearing_q) begin
        clr_q <= clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          clearing_q <= 1'b0;
        end
      end
      if (en_i) begin
        if (req_i.item.valid && (req_i.item.op == OP_BAKE)) begin
          baked_q <= 1'b1;
        end
        req_q.valid    <= req_i.item.valid && (req_i.item.op == OP_QUERY);
        req_q.blend_en <= baked_q && ({1'b0, req_i.item.ch} < 4'(CHANNEL_COUNT));
        req_q.ch_zero  <= (req_i.item.ch == '0);
        req_q.fx       <= req_i.fx;
        req_q.fy       <= req_i.fy;
        req_q.fz       <= req_i.fz;
      end
    end
  end

  assign req_o      = req_q;
  assign clearing_o = clearing_q;

endmodule

/* rtl/core/tgs_blend.sv */
// ----------------------------------------------------------------------------
// tgs_blend
// Three blend stages (x, y, z), the channel 0 bias with clamp, and the
// output register that sets the pipeline stall.
// ----------------------------------------------------------------------------
module tgs_blend (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  tgs_pkg::blend_req_t                  req_i,
  input  logic [tgs_pkg::CORNERS-1:0][tgs_pkg::LEVEL_W-1:0] data_i,
  input  logic [tgs_pkg::LEVEL_W-1:0]          energy_i,
  output logic                                 en_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [tgs_pkg::LEVEL_W-1:0]          level_o
);
  import tgs_pkg::*;

  blend_req_t               x_q, y_q, z_q;
  logic [3:0][LEVEL_W-1:0]  vx_q;
  logic [1:0][LEVEL_W-1:0]  vy_q;
  logic [LEVEL_W-1:0]       vz_q;
  logic                     out_valid_q;
  logic [LEVEL_W-1:0]       level_q;
  logic [LEVEL_W:0]         sum;
  logic [CORNERS-1:0][LEVEL_W-1:0] cells;

  assign en_o = !(out_valid_q && !out_ready_i && z_q.valid);

  always_comb begin
    for (int b = 0; b < CORNERS; b++) begin
      cells[b] = req_i.blend_en ? data_i[b] : '0;
    end
  end

  assign sum = {1'b0, vz_q} + (z_q.ch_zero ? {1'b0, energy_i} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q         <= '0;
      y_q         <= '0;
      z_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (en_o) begin
        x_q <= req_i;
        y_q <= x_q;
        z_q <= y_q;
        if (z_q.valid) begin
          out_valid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      for (int k = 0; k < 4; k++) begin
        vx_q[k] <= lerp16(cells[2*k], cells[2*k+1], req_i.fx);
      end
      vy_q[0] <= lerp16(vx_q[0], vx_q[1], x_q.fy);
      vy_q[1] <= lerp16(vx_q[2], vx_q[3], x_q.fy);
      vz_q    <= lerp16(vy_q[0], vy_q[1], y_q.fz);
      if (z_q.valid) begin
        level_q <= (sum > ONE_Q15) ? LEVEL_W'(ONE_Q15) : LEVEL_W'(sum);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign level_o     = level_q;

endmodule

/* rtl/core/trilinear_grid_sampler.sv */
// ----------------------------------------------------------------------------
// trilinear_grid_sampler
// Multi-channel 3D sample grid with trilinear lookup.
//
// Input stream: tuser carries the opcode (write sample, query, mark baked),
// tdata the position, channel, write index and write value. Output stream:
// one beat per query carrying the Q1.15 level; writes and marks give none.
// The config port writes one register per cycle with cfg_we_i. The user
// must write it only while the block is idle; the block does not enforce it.
// A query beat passes the address stages, store read, x, y and z blend
// stages and output register. Throughput: one beat per cycle unless the
// pipeline stalls; the eight corner reads come from eight copies of the
// store, each read once per cycle, all written on every in-range sample
// write. Reset: control and config registers return to defaults, the baked
// flag clears and the store is filled with one half, one entry per cycle,
// over all AXIS_CELLS^3 * CHANNEL_COUNT entries (16384 by default), while
// s_axis_tready stays low. Stall: the pipeline holds only while a result
// waits unread and another is ready to replace it; bubbles and inputs flow.
// ----------------------------------------------------------------------------
module trilinear_grid_sampler #(
  parameter int unsigned AXIS_CELLS    = tgs_pkg::AXIS_CELLS_DEF,
  parameter int unsigned CHANNEL_COUNT = tgs_pkg::CHANNEL_COUNT_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pos_x, pos_y, pos_z, channel_select, write_index, write_value, zero pad
  input  logic [135:0] s_axis_tdata,
  // opcode
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // level_out
  output logic [15:0]  m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [tgs_pkg::CFG_AW-1:0]    cfg_addr_i,
  input  logic [tgs_pkg::CFG_DW-1:0]    cfg_wdata_i
);
  import tgs_pkg::*;

  localparam int unsigned DEPTH = AXIS_CELLS * AXIS_CELLS * AXIS_CELLS * CHANNEL_COUNT;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SW    = $clog2(AXIS_CELLS + 1);
  localparam int unsigned GW    = $clog2(AXIS_CELLS * AXIS_CELLS + 1);

  logic [2:0][POS_W-1:0]    origin_q;
  logic [INV_W-1:0]         inv_q;
  logic [2:0][GSIZE_W-1:0]  gsize_q;
  logic [LEVEL_W-1:0]       energy_q;
  logic [2:0][SW-1:0]       geff;
  logic [GW-1:0]            gxy;
  logic                     en;
  logic                     clearing;
  item_ctl_t                item;
  logic [2:0][POS_W-1:0]    pos;
  addr_req_t                areq;
  logic [CORNERS-1:0][AW-1:0] addr;
  blend_req_t               breq;
  logic [CORNERS-1:0][LEVEL_W-1:0] cells;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q <= '0;
      inv_q    <= 24'd65536;
      gsize_q  <= {3{5'd16}};
      energy_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_ORIGIN_X: origin_q[0] <= cfg_wdata_i;
        CFG_ORIGIN_Y: origin_q[1] <= cfg_wdata_i;
        CFG_ORIGIN_Z: origin_q[2] <= cfg_wdata_i;
        CFG_INV_CELL: inv_q       <= cfg_wdata_i[INV_W-1:0];
        CFG_GRID_X:   gsize_q[0]  <= cfg_wdata_i[GSIZE_W-1:0];
        CFG_GRID_Y:   gsize_q[1]  <= cfg_wdata_i[GSIZE_W-1:0];
        CFG_GRID_Z:   gsize_q[2]  <= cfg_wdata_i[GSIZE_W-1:0];
        CFG_DYN_ENRG: energy_q    <= cfg_wdata_i[LEVEL_W-1:0];
        default:      energy_q    <= energy_q;
      endcase
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (gsize_q[a] == '0) begin
        geff[a] = SW'(1);
      end else if (32'(gsize_q[a]) > 32'(AXIS_CELLS)) begin
        geff[a] = SW'(AXIS_CELLS);
      end else begin
        geff[a] = SW'(gsize_q[a]);
      end
    end
    gxy = GW'(GW'(geff[0]) * GW'(geff[1]));
  end

  assign s_axis_tready = en && !clearing;

  always_comb begin
    item.valid = s_axis_tvalid && s_axis_tready;
    item.op    = s_axis_tuser;
    item.ch    = s_axis_tdata[98:96];
    item.widx  = s_axis_tdata[112:99];
    item.wval  = s_axis_tdata[128:113];
    pos[0]     = s_axis_tdata[31:0];
    pos[1]     = s_axis_tdata[63:32];
    pos[2]     = s_axis_tdata[95:64];
  end

  tgs_addr #(
    .AXIS_CELLS    (AXIS_CELLS),
    .CHANNEL_COUNT (CHANNEL_COUNT),
    .AW            (AW),
    .SW            (SW),
    .GW            (GW)
  ) u_addr (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .item_i   (item),
    .pos_i    (pos),
    .origin_i (origin_q),
    .inv_i    (inv_q),
    .gsize_i  (geff),
    .gxy_i    (gxy),
    .req_o    (areq),
    .addr_o   (addr)
  );

  tgs_store #(
    .CHANNEL_COUNT (CHANNEL_COUNT),
    .DEPTH         (DEPTH),
    .AW            (AW)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .req_i      (areq),
    .addr_i     (addr),
    .req_o      (breq),
    .data_o     (cells),
    .clearing_o (clearing)
  );

  tgs_blend u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (breq),
    .data_i      (cells),
    .energy_i    (energy_q),
    .en_o        (en),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .level_o     (m_axis_tdata)
  );

endmodule
